### rtl/core/swfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swfd_pkg
// Types and constants shared by the sync word frame deframer.
// ----------------------------------------------------------------------------
package swfd_pkg;

  // Sync sequence: two fixed words, then an id word matched under a mask.
  localparam logic [15:0] SyncWordA  = 16'hf00d;
  localparam logic [15:0] SyncWordB  = 16'hd0cc;
  localparam logic [15:0] IdMask     = 16'hfff0;
  localparam logic [15:0] IdValue    = 16'hae00;

  // Word positions within a frame, counted from the first sync word.
  localparam logic [15:0] OffsetId      = 16'd2;
  localparam logic [15:0] OffsetCountLo = 16'd3;
  localparam logic [15:0] OffsetCountHi = 16'd4;
  localparam logic [15:0] OffsetLength  = 16'd7;
  localparam logic [15:0] OffsetPayload = 16'd8;

  // Result queue depth; a power of two so the pointers wrap by themselves.
  localparam int unsigned ResFifoDepth = 4;
  localparam int unsigned ResPtrW      = $clog2(ResFifoDepth);
  localparam int unsigned ResCountW    = $clog2(ResFifoDepth + 1);

  localparam logic KindByte    = 1'b0;
  localparam logic KindTrailer = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic        last_byte;
    logic        source_flag;
    logic        parity_flag;
    logic [31:0] buffer_count;
    logic [15:0] payload_length;
    logic [15:0] checksum_word;
    logic [15:0] sw_end_word;
    logic [15:0] end_word;
    logic [15:0] aux_end_word;
  } result_t;

  // Up to two results are written into the queue per accepted word.
  typedef struct packed {
    logic [1:0] num;
    result_t    res0;
    result_t    res1;
  } res_push_t;

endpackage : swfd_pkg
`default_nettype wire

### rtl/core/swfd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swfd_word_if / swfd_res_if
// Valid/ready channels for link words and for deframer results.
// ----------------------------------------------------------------------------
interface swfd_word_if;
  logic        valid;
  logic        ready;
  logic [15:0] word_in;

  modport source (output valid, output word_in, input ready);
  modport sink   (input valid, input word_in, output ready);
endinterface : swfd_word_if

interface swfd_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic        last_byte;
  logic        source_flag;
  logic        parity_flag;
  logic [31:0] buffer_count;
  logic [15:0] payload_length;
  logic [15:0] checksum_word;
  logic [15:0] sw_end_word;
  logic [15:0] end_word;
  logic [15:0] aux_end_word;

  modport source (
    output valid, input ready,
    output kind, output payload_byte, output last_byte, output source_flag,
    output parity_flag, output buffer_count, output payload_length,
    output checksum_word, output sw_end_word, output end_word, output aux_end_word
  );
  modport sink (
    input valid, output ready,
    input kind, input payload_byte, input last_byte, input source_flag,
    input parity_flag, input buffer_count, input payload_length,
    input checksum_word, input sw_end_word, input end_word, input aux_end_word
  );
endinterface : swfd_res_if
`default_nettype wire

### rtl/core/swfd_res_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swfd_res_fifo
// Small result queue: pushes up to two results a cycle, pops one.
// ----------------------------------------------------------------------------
module swfd_res_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire swfd_pkg::res_push_t push_i,
  input  wire logic               pop_i,
  output      logic               room_o,
  output      logic               valid_o,
  output      swfd_pkg::result_t  head_o
);
  import swfd_pkg::*;

  result_t              mem_q [ResFifoDepth];
  logic [ResPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [ResPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [ResCountW-1:0] count_q, count_d;
  logic [ResPtrW-1:0]   wr_ptr_nxt;
  logic                 do_pop;

  assign valid_o    = (count_q != '0);
  assign head_o     = mem_q[rd_ptr_q];
  // Room for a full pair keeps every accepted word's results in hand.
  assign room_o     = (count_q <= ResCountW'(ResFifoDepth - 2));
  assign do_pop     = pop_i && valid_o;
  assign wr_ptr_nxt = wr_ptr_q + ResPtrW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + ResPtrW'(push_i.num);
    rd_ptr_d = rd_ptr_q + ResPtrW'(do_pop);
    count_d  = count_q + ResCountW'(push_i.num) - ResCountW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push_i.res1;
    end
  end

endmodule : swfd_res_fifo
`default_nettype wire

### rtl/core/sync_word_frame_deframer_unit.sv
`default_nettype none
// A result is registered in the result queue before it is offered on the output.
// Words are taken one per cycle while the result queue has room, both while hunting
// and in the header; a payload word gives two bytes, which leave through the single result port one at a time.
// The four-entry result queue takes a word whenever two entries are free.
// Reset (asynchronous, active low) clears the sync window, frame state and queue.
// ----------------------------------------------------------------------------
// sync_word_frame_deframer_unit
// Hunts for the F00D, D0CC, AE0x sync sequence in a 16-bit word stream,
// unpacks the frame header, emits payload bytes and one trailer summary.
// ----------------------------------------------------------------------------
module sync_word_frame_deframer_unit (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  swfd_word_if.sink     word_chan_i,
  swfd_res_if.source    res_chan_o
);
  import swfd_pkg::*;

  // Frame and hunt state. All of it takes its value only on an accepted word.
  logic [15:0] hist_new_q, hist_new_d;   // newer hunted word
  logic [15:0] hist_old_q, hist_old_d;   // older hunted word
  logic        in_frame_q, in_frame_d;
  logic [15:0] offset_q, offset_d;       // position of the last word taken
  logic [1:0]  flags_q, flags_d;         // id word bits 1..0
  logic [31:0] count_q, count_d;
  logic [15:0] length_q, length_d;
  logic [15:0] sent_q, sent_d;           // payload bytes given so far
  logic [15:0] trl_q [3];
  logic [15:0] trl_d [3];

  logic        accept;
  logic        room;
  logic        fifo_valid;
  result_t     head;
  res_push_t   push;

  logic [15:0] word;
  logic [15:0] off;
  logic [15:0] pos;
  logic [15:0] half;
  logic [15:0] sent_one;
  logic [15:0] sent_two;

  // A byte result carries the header fields seen so far; trailer words are zero.
  function automatic result_t make_byte(logic [7:0] b, logic last, logic [1:0] flg,
                                        logic [31:0] cnt, logic [15:0] len);
    result_t r;
    r                = '0;
    r.kind           = KindByte;
    r.payload_byte   = b;
    r.last_byte      = last;
    r.source_flag    = flg[0];
    r.parity_flag    = flg[1];
    r.buffer_count   = cnt;
    r.payload_length = len;
    return r;
  endfunction

  assign word     = word_chan_i.word_in;
  assign accept   = word_chan_i.valid && room;
  assign word_chan_i.ready = room;

  assign off      = offset_q + 16'd1;
  assign pos      = off - OffsetPayload;
  assign half     = {1'b0, length_q[15:1]};
  assign sent_one = sent_q + 16'd1;
  assign sent_two = sent_q + 16'd2;

  always_comb begin
    hist_new_d = hist_new_q;
    hist_old_d = hist_old_q;
    in_frame_d = in_frame_q;
    offset_d   = offset_q;
    flags_d    = flags_q;
    count_d    = count_q;
    length_d   = length_q;
    sent_d     = sent_q;
    trl_d      = trl_q;
    push       = '0;

    if (accept) begin
      if (!in_frame_q) begin
        // Hunting: the window slips one word on every miss.
        if (hist_old_q == SyncWordA && hist_new_q == SyncWordB &&
            (word & IdMask) == IdValue) begin
          in_frame_d = 1'b1;
          offset_d   = OffsetId;
          flags_d    = word[1:0];
          count_d    = '0;
          length_d   = '0;
          sent_d     = '0;
          trl_d[0]   = '0;
          trl_d[1]   = '0;
          trl_d[2]   = '0;
          hist_new_d = '0;
          hist_old_d = '0;
        end else begin
          hist_old_d = hist_new_q;
          hist_new_d = word;
        end
      end else begin
        offset_d = off;
        if (off == OffsetCountLo) begin
          count_d[15:0] = word;
        end else if (off == OffsetCountHi) begin
          count_d[31:16] = word;
        end else if (off == OffsetLength) begin
          length_d = word;
        end else if (off >= OffsetPayload) begin
          if (pos < half) begin
            // Full payload word: low byte first, then high byte.
            push.num  = 2'd2;
            push.res0 = make_byte(word[7:0], sent_one == length_q, flags_q,
                                  count_q, length_q);
            push.res1 = make_byte(word[15:8], sent_two == length_q, flags_q,
                                  count_q, length_q);
            sent_d    = sent_two;
          end else if (pos == half) begin
            // Checksum word; with an odd length its low byte is the last byte.
            trl_d[0] = word;
            if (length_q[0]) begin
              push.num  = 2'd1;
              push.res0 = make_byte(word[7:0], sent_one == length_q, flags_q,
                                    count_q, length_q);
              sent_d    = sent_one;
            end
          end else if (pos == half + 16'd1) begin
            trl_d[1] = word;
          end else if (pos == half + 16'd2) begin
            trl_d[2] = word;
          end else begin
            // Final end word closes the frame and the hunt restarts clean.
            push.num                 = 2'd1;
            push.res0                = '0;
            push.res0.kind           = KindTrailer;
            push.res0.source_flag    = flags_q[0];
            push.res0.parity_flag    = flags_q[1];
            push.res0.buffer_count   = count_q;
            push.res0.payload_length = length_q;
            push.res0.checksum_word  = trl_q[0];
            push.res0.sw_end_word    = trl_q[1];
            push.res0.end_word       = trl_q[2];
            push.res0.aux_end_word   = word;
            in_frame_d = 1'b0;
            offset_d   = '0;
            hist_new_d = '0;
            hist_old_d = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_new_q <= '0;
      hist_old_q <= '0;
      in_frame_q <= 1'b0;
      offset_q   <= '0;
      flags_q    <= '0;
      count_q    <= '0;
      length_q   <= '0;
      sent_q     <= '0;
      trl_q[0]   <= '0;
      trl_q[1]   <= '0;
      trl_q[2]   <= '0;
    end else begin
      hist_new_q <= hist_new_d;
      hist_old_q <= hist_old_d;
      in_frame_q <= in_frame_d;
      offset_q   <= offset_d;
      flags_q    <= flags_d;
      count_q    <= count_d;
      length_q   <= length_d;
      sent_q     <= sent_d;
      trl_q      <= trl_d;
    end
  end

  // The result queue decouples the output side, so words keep flowing while
  // a finished result waits to be taken.
  swfd_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (res_chan_o.ready),
    .room_o  (room),
    .valid_o (fifo_valid),
    .head_o  (head)
  );

  assign res_chan_o.valid          = fifo_valid;
  assign res_chan_o.kind           = head.kind;
  assign res_chan_o.payload_byte   = head.payload_byte;
  assign res_chan_o.last_byte      = head.last_byte;
  assign res_chan_o.source_flag    = head.source_flag;
  assign res_chan_o.parity_flag    = head.parity_flag;
  assign res_chan_o.buffer_count   = head.buffer_count;
  assign res_chan_o.payload_length = head.payload_length;
  assign res_chan_o.checksum_word  = head.checksum_word;
  assign res_chan_o.sw_end_word    = head.sw_end_word;
  assign res_chan_o.end_word       = head.end_word;
  assign res_chan_o.aux_end_word   = head.aux_end_word;

endmodule : sync_word_frame_deframer_unit
`default_nettype wire

### dv/sync_word_frame_deframer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sync_word_frame_deframer_unit_tb
// Feeds link words into the deframer through its request channel and keeps
// a cycle-free model of the sync hunt and frame unpacking alongside it.
// Every accepted word updates that model, which queues the payload bytes and
// trailer summaries the block must return. A checker pops them in order and
// compares every field. Directed frames and one long receiver hold-off cover
// the corner cases. Random frames, noise and broken sync runs then follow
// under several idle and stall patterns.
// ----------------------------------------------------------------------------
module sync_word_frame_deframer_unit_tb;
  import swfd_pkg::*;

  localparam int unsigned CycleLimit    = 1000000;
  localparam int unsigned DrainCycles   = 20;
  localparam int unsigned MaxSenderGap  = 50;
  localparam int unsigned HoldOffCycles = 200;
  localparam int unsigned MaxPrinted    = 20;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  swfd_word_if word_if ();
  swfd_res_if  res_if ();

  sync_word_frame_deframer_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .word_chan_i (word_if),
    .res_chan_o  (res_if)
  );

  always #5 clk_i = ~clk_i;

  // Idle settings. The sender percentage is only read by the sending task,
  // so it is set directly; the stall percentage and the hold-off flag are
  // read by the ready process and change by nonblocking assignment.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        receiver_hold  = 1'b0;

  // Expected results, oldest first, and run statistics.
  result_t     expected_results[$];
  int unsigned mismatch_count  = 0;
  int unsigned words_sent      = 0;
  int unsigned frames_locked   = 0;
  int unsigned results_checked = 0;
  int unsigned cycle_count     = 0;

  // Deframer state as the predictor sees it.
  logic [15:0] hist_new;
  logic [15:0] hist_old;
  logic        locked;
  logic [15:0] frame_pos;
  logic [1:0]  id_bits;
  logic [31:0] buf_count;
  logic [15:0] pay_len;
  logic [15:0] bytes_out;
  logic [15:0] chk_word;
  logic [15:0] sw_end_seen;
  logic [15:0] end_seen;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Fields shared by both result kinds; everything else stays zero.
  function automatic result_t frame_result(input logic kind);
    result_t r;
    r                = '0;
    r.kind           = kind;
    r.source_flag    = id_bits[0];
    r.parity_flag    = id_bits[1];
    r.buffer_count   = buf_count;
    r.payload_length = pay_len;
    return r;
  endfunction

  task automatic queue_payload_byte(input logic [7:0] b);
    result_t r;
    r              = frame_result(KindByte);
    r.payload_byte = b;
    bytes_out      = bytes_out + 16'd1;
    r.last_byte    = (bytes_out == pay_len);
    expected_results.push_back(r);
  endtask

  // Advances the model by one accepted link word.
  task automatic predict_word(input logic [15:0] w);
    logic [15:0] pos;
    logic [15:0] half;
    logic [15:0] idx;
    result_t     r;
    if (!locked) begin
      // Hunting: the two previous words must be the fixed sync words and
      // this one must be an id word under the mask.
      if (hist_old == SyncWordA && hist_new == SyncWordB &&
          (w & IdMask) == IdValue) begin
        locked      = 1'b1;
        frame_pos   = OffsetId;
        id_bits     = w[1:0];
        buf_count   = '0;
        pay_len     = '0;
        bytes_out   = '0;
        chk_word    = '0;
        sw_end_seen = '0;
        end_seen    = '0;
        hist_old    = '0;
        hist_new    = '0;
        frames_locked++;
      end else begin
        hist_old = hist_new;
        hist_new = w;
      end
    end else begin
      pos       = frame_pos + 16'd1;
      frame_pos = pos;
      if (pos == OffsetCountLo) begin
        buf_count[15:0] = w;
      end else if (pos == OffsetCountHi) begin
        buf_count[31:16] = w;
      end else if (pos == OffsetLength) begin
        pay_len = w;
      end else if (pos >= OffsetPayload) begin
        half = pay_len >> 1;
        idx  = pos - OffsetPayload;
        if (idx < half) begin
          queue_payload_byte(w[7:0]);
          queue_payload_byte(w[15:8]);
        end else if (idx == half) begin
          // With an odd length the last payload byte rides in the low half
          // of the checksum word.
          chk_word = w;
          if (pay_len[0]) begin
            queue_payload_byte(w[7:0]);
          end
        end else if (idx == half + 16'd1) begin
          sw_end_seen = w;
        end else if (idx == half + 16'd2) begin
          end_seen = w;
        end else begin
          r               = frame_result(KindTrailer);
          r.checksum_word = chk_word;
          r.sw_end_word   = sw_end_seen;
          r.end_word      = end_seen;
          r.aux_end_word  = w;
          expected_results.push_back(r);
          // Back to hunting with an empty window.
          locked    = 1'b0;
          frame_pos = '0;
          hist_old  = '0;
          hist_new  = '0;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sending side
  // --------------------------------------------------------------------------

  // Offers one word and returns right after the edge that accepts it, so a
  // following call drives the next request in the same time step and the
  // valid line never drops between back-to-back requests.
  task automatic send_word(input logic [15:0] w);
    int unsigned gap;
    gap = 0;
    while (gap < MaxSenderGap && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      word_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    word_if.valid   <= 1'b1;
    word_if.word_in <= w;
    do @(posedge clk_i); while (!word_if.ready);
    words_sent++;
    predict_word(w);
  endtask

  // Sync run, id word, count, two ignored words and the length.
  task automatic send_header(input logic [3:0] id_low, input logic [31:0] count,
                             input logic [15:0] len);
    send_word(SyncWordA);
    send_word(SyncWordB);
    send_word(IdValue | {12'h000, id_low});
    send_word(count[15:0]);
    send_word(count[31:16]);
    send_word(16'($urandom));
    send_word(16'($urandom));
    send_word(len);
  endtask

  // Complete frame with random payload, checksum and end words.
  task automatic send_frame(input logic [3:0] id_low, input logic [31:0] count,
                            input logic [15:0] len);
    int unsigned body_words;
    body_words = (len >> 1) + 4;
    send_header(id_low, count, len);
    repeat (body_words) send_word(16'($urandom));
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // --------------------------------------------------------------------------
  // Receiving side
  // --------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (receiver_hold) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MaxPrinted) begin
      $display("%0t ns: MISMATCH %s", $time, msg);
    end
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d field %s: got %h, expected %h",
                                results_checked, name, got, want));
    end
  endtask

  // Every result taken from the block is compared with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    result_t got;
    result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.kind           = res_if.kind;
      got.payload_byte   = res_if.payload_byte;
      got.last_byte      = res_if.last_byte;
      got.source_flag    = res_if.source_flag;
      got.parity_flag    = res_if.parity_flag;
      got.buffer_count   = res_if.buffer_count;
      got.payload_length = res_if.payload_length;
      got.checksum_word  = res_if.checksum_word;
      got.sw_end_word    = res_if.sw_end_word;
      got.end_word       = res_if.end_word;
      got.aux_end_word   = res_if.aux_end_word;
      if (expected_results.size() == 0) begin
        report_mismatch("result arrived with nothing expected");
      end else begin
        want = expected_results.pop_front();
        check_field("kind", 32'(got.kind), 32'(want.kind));
        check_field("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
        check_field("last_byte", 32'(got.last_byte), 32'(want.last_byte));
        check_field("source_flag", 32'(got.source_flag), 32'(want.source_flag));
        check_field("parity_flag", 32'(got.parity_flag), 32'(want.parity_flag));
        check_field("buffer_count", got.buffer_count, want.buffer_count);
        check_field("payload_length", 32'(got.payload_length),
                    32'(want.payload_length));
        check_field("checksum_word", 32'(got.checksum_word), 32'(want.checksum_word));
        check_field("sw_end_word", 32'(got.sw_end_word), 32'(want.sw_end_word));
        check_field("end_word", 32'(got.end_word), 32'(want.end_word));
        check_field("aux_end_word", 32'(got.aux_end_word), 32'(want.aux_end_word));
      end
      results_checked++;
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results still expected",
               cycle_count, expected_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes, both flags, and the zero, one and odd length cases.
  task automatic test_directed_frames();
    set_idling(0, 0);
    send_word(16'h0000);
    send_word(16'hffff);
    send_frame(4'h0, 32'h0000_0000, 16'd0);
    send_frame(4'hf, 32'hffff_ffff, 16'd1);
    send_frame(4'h2, 32'h1234_5678, 16'd2);
    send_frame(4'h1, 32'h8000_0001, 16'd5);
    send_frame(4'h3, 32'h0001_ffff, 16'd4);
  endtask

  // Sync hunting: window slips, masked id misses, sync words inside a frame
  // and the window clear after a frame.
  task automatic test_sync_hunting();
    set_idling(0, 0);
    // An extra leading sync word: the window slips by one and still locks.
    send_word(SyncWordA);
    send_frame(4'h6, $urandom, 16'd3);
    // Id word outside the mask, then wrong second word: neither locks.
    send_word(SyncWordA);
    send_word(SyncWordB);
    send_word(IdValue | 16'h0010);
    send_word(SyncWordA);
    send_word(SyncWordA ^ 16'h0001);
    send_word(IdValue);
    // Sync words in the payload are plain data.
    send_header(4'h9, $urandom, 16'd6);
    send_word(SyncWordA);
    send_word(SyncWordB);
    send_word(IdValue);
    // Checksum and end words that look like a sync run must not carry over:
    // the id word right after the frame hits an empty window.
    send_word(SyncWordA);
    send_word(SyncWordB);
    send_word(SyncWordA);
    send_word(SyncWordB);
    send_word(IdValue | 16'h0001);
    send_frame(4'ha, $urandom, 16'd0);
  endtask

  // One long frame of odd length, without idling to keep it short.
  task automatic test_long_frame();
    set_idling(0, 0);
    send_frame(4'hc, $urandom, 16'd61);
  endtask

  // The receiver holds off long enough for the result queue to fill and
  // stall the link side while the sender keeps offering.
  task automatic test_backpressure();
    set_idling(0, 0);
    fork
      begin
        receiver_hold <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
        receiver_hold <= 1'b0;
      end
      begin
        send_frame(4'h5, $urandom, 16'd48);
        send_frame(4'h7, $urandom, 16'd9);
      end
    join
  endtask

  // Mostly well-formed frames with random content, mixed with noise and
  // broken sync runs. Only frame words count toward the target.
  task automatic test_random_traffic(input int unsigned target_words);
    int unsigned counted;
    int unsigned pick;
    logic [15:0] len;
    logic [15:0] w;
    counted = 0;
    while (counted < target_words) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = 16'(($urandom_range(9) == 0) ? $urandom_range(25, 200)
                                            : $urandom_range(24));
        send_frame(4'($urandom), $urandom, len);
        counted += 10 + (len >> 1);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) send_word(16'($urandom));
      end else begin
        send_word(SyncWordA);
        if ($urandom_range(1)) begin
          send_word(SyncWordB);
          w = 16'($urandom);
          if ((w & IdMask) == IdValue) w = w ^ 16'h0100;
          send_word(w);
        end else begin
          send_word(16'($urandom));
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Run
  // --------------------------------------------------------------------------

  initial begin
    word_if.valid   = 1'b0;
    word_if.word_in = '0;
    res_if.ready    = 1'b0;
    locked          = 1'b0;
    frame_pos       = '0;
    hist_new        = '0;
    hist_old        = '0;
    id_bits         = '0;
    buf_count       = '0;
    pay_len         = '0;
    bytes_out       = '0;
    chk_word        = '0;
    sw_end_seen     = '0;
    end_seen        = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_frames();
    test_sync_hunting();
    test_long_frame();
    test_backpressure();
    set_idling(0, 0);
    test_random_traffic(50);
    set_idling(83, 0);
    test_random_traffic(50);
    set_idling(0, 83);
    test_random_traffic(50);
    set_idling(21, 21);
    test_random_traffic(50);

    // Stop offering, let the receiver drain, then watch for stray results.
    word_if.valid <= 1'b0;
    set_idling(0, 0);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d link words, %0d frames locked, %0d results compared,",
             words_sent, frames_locked, results_checked);
    $display("with a long odd-length frame, a %0d-cycle receiver hold-off and four idle mixes.",
             HoldOffCycles);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule : sync_word_frame_deframer_unit_tb
